### rtl/core/flasi_pkg.sv
// ----------------------------------------------------------------------------
// flasi_pkg
// Shared types, codes and constants of the four-line serial interface.
// ----------------------------------------------------------------------------
package flasi_pkg;

	// Default sizes
	localparam int LINE_COUNT_DEF = 4;
	localparam int FIFO_DEPTH_DEF = 64;

	// Depth of the command and result queues
	localparam int QUEUE_DEPTH = 2;

	// Item kinds
	localparam logic [1:0] KIND_READ    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_RX      = 2'd2;
	localparam logic [1:0] KIND_CARRIER = 2'd3;

	// Register offsets within a line
	localparam logic [1:0] SUB_RCSR = 2'd0;
	localparam logic [1:0] SUB_RBUF = 2'd1;
	localparam logic [1:0] SUB_TSCR = 2'd2;
	localparam logic [1:0] SUB_TBUF = 2'd3;

	// Command opcodes between front and back
	localparam logic [2:0] OP_NOP     = 3'd0;
	localparam logic [2:0] OP_RD_RCSR = 3'd1;
	localparam logic [2:0] OP_RD_RBUF = 3'd2;
	localparam logic [2:0] OP_RD_TSCR = 3'd3;
	localparam logic [2:0] OP_RD_TBUF = 3'd4;
	localparam logic [2:0] OP_WRITE   = 3'd5;
	localparam logic [2:0] OP_RX_BYTE = 3'd6;
	localparam logic [2:0] OP_CARRIER = 3'd7;

	// Status register bits
	localparam logic [15:0] RCSR_DTR_CD     = 16'h0005;
	localparam logic [15:0] RCSR_ERR_MASK   = 16'hE000;
	localparam logic [15:0] RCSR_CONNECT    = 16'hE000;
	localparam logic [15:0] RCSR_DISCONNECT = 16'hA000;
	localparam logic [15:0] TSCR_CTS_READY  = 16'h0082;
	localparam int BIT_PARITY = 5;
	localparam int BIT_IE     = 6;
	localparam int BIT_DONE   = 7;

	// Interrupt vector
	localparam logic [8:0] VECTOR_TX_OFFSET = 9'd4;

	// Configuration registers
	localparam int         PADDR_W         = 3;
	localparam int         PADDR_IDX_BIT   = 2;
	localparam logic       REG_VECTOR_BASE = 1'b0;
	localparam logic       REG_IRQ_LEVEL   = 1'b1;
	localparam logic [8:0] VECTOR_BASE_RST = 9'd192;
	localparam logic [2:0] IRQ_LEVEL_RST   = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  address_offset;
		logic        byte_access;
		logic [15:0] write_data;
		logic [1:0]  line_select;
		logic [7:0]  rx_byte;
		logic        carrier;
	} in_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        tx_valid;
		logic [1:0]  tx_line;
		logic [6:0]  tx_char;
		logic        irq_valid;
		logic [8:0]  irq_vector;
		logic [2:0]  irq_level;
	} out_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  line;
		logic [1:0]  sub;
		logic        hi;
		logic        byte_acc;
		logic [15:0] data;
		logic        carrier;
	} cmd_t;

endpackage

### rtl/core/flasi_front.sv
// ----------------------------------------------------------------------------
// flasi_front
// Accepts items, classifies them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module flasi_front #(
	parameter int LINE_COUNT = flasi_pkg::LINE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  flasi_pkg::in_t   in_item,
	output logic             cmd_valid,
	input  logic             cmd_pop,
	output flasi_pkg::cmd_t  cmd
);
	import flasi_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           cmd_d;
	logic [4:0]     bus_line_ext;
	logic [4:0]     ev_line_ext;
	logic           bus_ok;
	logic           ev_ok;
	logic           wr_en;
	cmd_t           q_mem [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	// Classify the incoming item
	always_comb begin
		bus_line_ext = {3'b000, in_item.address_offset[4:3]};
		ev_line_ext  = {3'b000, in_item.line_select};
		bus_ok       = bus_line_ext < 5'(LINE_COUNT);
		ev_ok        = ev_line_ext < 5'(LINE_COUNT);
		cmd_d          = '0;
		cmd_d.sub      = in_item.address_offset[2:1];
		cmd_d.hi       = in_item.address_offset[0];
		cmd_d.byte_acc = in_item.byte_access;
		cmd_d.carrier  = in_item.carrier;
		cmd_d.op       = OP_NOP;
		if (in_item.kind == KIND_READ || in_item.kind == KIND_WRITE) begin
			cmd_d.line = in_item.address_offset[4:3];
			cmd_d.data = in_item.write_data;
		end else begin
			cmd_d.line = in_item.line_select;
			cmd_d.data = {8'h00, in_item.rx_byte};
		end
		unique case (in_item.kind)
			KIND_READ: begin
				if (bus_ok) begin
					unique case (in_item.address_offset[2:1])
						SUB_RCSR: cmd_d.op = OP_RD_RCSR;
						SUB_RBUF: cmd_d.op = OP_RD_RBUF;
						SUB_TSCR: cmd_d.op = OP_RD_TSCR;
						default:  cmd_d.op = OP_RD_TBUF;
					endcase
				end
			end
			KIND_WRITE:   cmd_d.op = bus_ok ? OP_WRITE : OP_NOP;
			KIND_RX:      cmd_d.op = ev_ok ? OP_RX_BYTE : OP_NOP;
			default:      cmd_d.op = ev_ok ? OP_CARRIER : OP_NOP;
		endcase
	end

	assign full      = (count_q == QCW'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign wr_en     = push && !full;
	assign cmd       = q_mem[rd_ptr_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_ptr_q] <= cmd_d;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/flasi_back.sv
// ----------------------------------------------------------------------------
// flasi_back
// Executes commands against the line registers and receive FIFOs.
// ----------------------------------------------------------------------------
module flasi_back #(
	parameter int LINE_COUNT = flasi_pkg::LINE_COUNT_DEF,
	parameter int FIFO_DEPTH = flasi_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [8:0]       vector_base,
	input  logic [2:0]       interrupt_level,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  flasi_pkg::cmd_t  cmd,
	input  logic             res_full,
	output logic             res_push,
	output flasi_pkg::out_t  res
);
	import flasi_pkg::*;

	localparam int LIW       = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam int PW        = $clog2(FIFO_DEPTH);
	localparam int CW        = $clog2(FIFO_DEPTH + 1);
	localparam int MEM_DEPTH = LINE_COUNT * FIFO_DEPTH;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WAIT = 1'b1;

	logic            state_q;
	logic            state_d;
	cmd_t            cmd_q;
	cmd_t            cur;

	logic [15:0]     rcsr_q  [LINE_COUNT];
	logic [15:0]     rbuf_q  [LINE_COUNT];
	logic [15:0]     tscr_q  [LINE_COUNT];
	logic [15:0]     tbuf_q  [LINE_COUNT];
	logic [PW-1:0]   head_q  [LINE_COUNT];
	logic [PW-1:0]   tail_q  [LINE_COUNT];
	logic [CW-1:0]   count_q [LINE_COUNT];
	logic [LINE_COUNT-1:0] conn_q;

	logic [7:0]      fifo_mem [MEM_DEPTH];
	logic [7:0]      mem_rd_q;

	logic [4:0]      line_ext;
	logic [LIW-1:0]  idx;
	logic [AW-1:0]   line_base;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;

	logic [15:0]     rcsr, rbuf, tscr, tbuf;
	logic [PW-1:0]   head, tail;
	logic [CW-1:0]   count;
	logic            conn;

	logic [15:0]     rcsr_nx, rbuf_nx, tscr_nx, tbuf_nx;
	logic [PW-1:0]   head_nx, tail_nx;
	logic [CW-1:0]   count_nx;
	logic            conn_nx;

	logic            rbuf_pend;
	logic            start;
	logic            mem_re;
	logic            mem_we;
	logic            exec;
	logic [15:0]     old_word;
	logic [15:0]     wv;
	logic [15:0]     rd_v;
	logic            tx_send;
	logic            irq_rx;
	logic            irq_tx;

	// Select the command in work and its line state
	assign cur       = (state_q == ST_WAIT) ? cmd_q : cmd;
	assign line_ext  = {3'b000, cur.line};
	assign idx       = line_ext[LIW-1:0];
	assign rcsr      = rcsr_q[idx];
	assign rbuf      = rbuf_q[idx];
	assign tscr      = tscr_q[idx];
	assign tbuf      = tbuf_q[idx];
	assign head      = head_q[idx];
	assign tail      = tail_q[idx];
	assign count     = count_q[idx];
	assign conn      = conn_q[idx];
	assign line_base = AW'(idx * FIFO_DEPTH);
	assign wr_addr   = line_base + AW'(tail);
	assign rd_addr   = line_base + AW'(head);

	// Sequence: a receive buffer read with bytes waiting first reads the FIFO memory
	assign rbuf_pend = (cur.op == OP_RD_RBUF) && (count != '0);
	assign start     = (state_q == ST_IDLE) && cmd_valid && !res_full;
	assign cmd_pop   = start;
	assign mem_re    = start && rbuf_pend;
	assign exec      = (start && !rbuf_pend) || (state_q == ST_WAIT);
	assign res_push  = exec;

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = mem_re ? ST_WAIT : ST_IDLE;
			ST_WAIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Merge byte writes into the addressed word
	always_comb begin
		case (cur.sub)
			SUB_RCSR: old_word = rcsr;
			SUB_RBUF: old_word = rbuf;
			SUB_TSCR: old_word = tscr;
			default:  old_word = tbuf;
		endcase
		if (!cur.byte_acc) begin
			wv = cur.data;
		end else if (cur.hi) begin
			wv = {cur.data[7:0], old_word[7:0]};
		end else begin
			wv = {old_word[15:8], cur.data[7:0]};
		end
	end

	// Work out the effect of the command
	always_comb begin
		rcsr_nx  = rcsr;
		rbuf_nx  = rbuf;
		tscr_nx  = tscr;
		tbuf_nx  = tbuf;
		head_nx  = head;
		tail_nx  = tail;
		count_nx = count;
		conn_nx  = conn;
		mem_we   = 1'b0;
		rd_v     = '0;
		tx_send  = 1'b0;
		irq_rx   = 1'b0;
		irq_tx   = 1'b0;
		if (exec) begin
			case (cur.op)
				OP_RD_RCSR: begin
					rd_v    = (rcsr & ~RCSR_DTR_CD) | (conn ? RCSR_DTR_CD : 16'h0000);
					rcsr_nx = rd_v & ~RCSR_ERR_MASK;
				end
				OP_RD_RBUF: begin
					if (state_q == ST_WAIT) begin
						rd_v                = {8'h00, mem_rd_q};
						rcsr_nx[BIT_PARITY] = ^mem_rd_q;
						head_nx  = (head == PW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
						count_nx = count - 1'b1;
						if (count_nx != '0) begin
							rcsr_nx[BIT_DONE] = 1'b1;
							irq_rx            = rcsr[BIT_IE];
						end
					end else begin
						rd_v = rbuf;
					end
				end
				OP_RD_TSCR: begin
					rd_v    = (tscr & ~TSCR_CTS_READY) | (conn ? TSCR_CTS_READY : 16'h0000);
					tscr_nx = rd_v;
				end
				OP_RD_TBUF: rd_v = tbuf;
				OP_WRITE: begin
					case (cur.sub)
						SUB_RCSR: rcsr_nx = wv;
						SUB_RBUF: rbuf_nx = wv;
						SUB_TSCR: tscr_nx = wv;
						default: begin
							tbuf_nx = wv;
							tx_send = 1'b1;
							irq_tx  = tscr[BIT_IE];
						end
					endcase
				end
				OP_RX_BYTE: begin
					if (count != CW'(FIFO_DEPTH)) begin
						mem_we            = 1'b1;
						tail_nx  = (tail == PW'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
						count_nx          = count + 1'b1;
						rcsr_nx[BIT_DONE] = 1'b1;
						irq_rx            = rcsr[BIT_IE];
					end
				end
				OP_CARRIER: begin
					if (conn != cur.carrier) begin
						conn_nx = cur.carrier;
						rcsr_nx = rcsr | (cur.carrier ? RCSR_CONNECT : RCSR_DISCONNECT);
						irq_rx  = rcsr[BIT_IE];
					end
				end
				default: ;
			endcase
		end
	end

	// Build the result
	always_comb begin
		res = '0;
		if (!cur.byte_acc) begin
			res.read_data = rd_v;
		end else if (cur.hi) begin
			res.read_data = {8'h00, rd_v[15:8]};
		end else begin
			res.read_data = {8'h00, rd_v[7:0]};
		end
		if (tx_send) begin
			res.tx_valid = 1'b1;
			res.tx_line  = cur.line;
			res.tx_char  = wv[6:0];
		end
		if (irq_rx || irq_tx) begin
			res.irq_valid  = 1'b1;
			res.irq_vector = vector_base + 9'({cur.line, 3'b000})
				+ (irq_tx ? VECTOR_TX_OFFSET : 9'd0);
			res.irq_level  = interrupt_level;
		end
	end

	// Receive FIFO storage, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			fifo_mem[wr_addr] <= cur.data[7:0];
		end
		if (mem_re) begin
			mem_rd_q <= fifo_mem[rd_addr];
		end
	end

	// Hold the command across the registered memory read
	always_ff @(posedge clk) begin
		if (mem_re) begin
			cmd_q <= cmd;
		end
	end

	// Update line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			conn_q  <= '0;
			for (int i = 0; i < LINE_COUNT; i++) begin
				rcsr_q[i]  <= '0;
				rbuf_q[i]  <= '0;
				tscr_q[i]  <= '0;
				tbuf_q[i]  <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (exec) begin
				rcsr_q[idx]  <= rcsr_nx;
				rbuf_q[idx]  <= rbuf_nx;
				tscr_q[idx]  <= tscr_nx;
				tbuf_q[idx]  <= tbuf_nx;
				head_q[idx]  <= head_nx;
				tail_q[idx]  <= tail_nx;
				count_q[idx] <= count_nx;
				conn_q[idx]  <= conn_nx;
			end
		end
	end

endmodule

### rtl/core/flasi_resq.sv
// ----------------------------------------------------------------------------
// flasi_resq
// Result queue that parts the back from the receiver of results.
// ----------------------------------------------------------------------------
module flasi_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	output logic             res_full,
	input  flasi_pkg::out_t  res,
	output logic             empty,
	input  logic             pop,
	output flasi_pkg::out_t  out_item
);
	import flasi_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	out_t           q_mem [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           rd_en;

	assign res_full = (count_q == QCW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_en    = pop && !empty;
	assign out_item = q_mem[rd_ptr_q];

	// Hold waiting results
	always_ff @(posedge clk) begin
		if (res_push) begin
			q_mem[wr_ptr_q] <= res;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (res_push && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!res_push && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/four_line_async_serial_interface.sv
// ----------------------------------------------------------------------------
// four_line_async_serial_interface
// Four serial line register blocks with receive FIFOs behind a queue port.
// ----------------------------------------------------------------------------
// Usage:
//   Items (bus reads and writes, arriving bytes, carrier reports) enter on
//   in_item with push/full; each gives one beat on out_item with empty/pop.
//   A beat carries the read value, any character sent and any interrupt.
//   vector_base and interrupt_level sit on the APB port at 0x0 and 0x4.
// Path: an accepted item is registered in the command queue, executed, and
//   its result registered in the result queue; a receive buffer read with
//   bytes waiting also passes the registered read of the FIFO memory.
// Throughput: one item per cycle unless the result queue is full; a receive
//   buffer read popping a byte holds the execution unit over its FIFO read.
// Reset: registers, FIFOs and carrier states clear, both queues empty, the
//   configuration registers take 192 and 5. No clearing pass is needed.
// Stall: when the result queue fills the execution unit waits, the command
//   queue fills behind it and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module four_line_async_serial_interface #(
	parameter int LINE_COUNT = flasi_pkg::LINE_COUNT_DEF,
	parameter int FIFO_DEPTH = flasi_pkg::FIFO_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  flasi_pkg::in_t                in_item,
	output logic                          empty,
	input  logic                          pop,
	output flasi_pkg::out_t               out_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flasi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import flasi_pkg::*;

	logic       cmd_valid;
	logic       cmd_pop;
	cmd_t       cmd;
	logic       res_full;
	logic       res_push;
	out_t       res;
	logic [8:0] vector_base_q;
	logic [2:0] irq_level_q;
	logic       cfg_wr;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_base_q <= VECTOR_BASE_RST;
			irq_level_q   <= IRQ_LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_IDX_BIT])
				REG_VECTOR_BASE: vector_base_q <= pwdata[8:0];
				default:         irq_level_q   <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[PADDR_IDX_BIT])
			REG_VECTOR_BASE: prdata = {23'd0, vector_base_q};
			default:         prdata = {29'd0, irq_level_q};
		endcase
	end

	flasi_front #(
		.LINE_COUNT (LINE_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	flasi_back #(
		.LINE_COUNT (LINE_COUNT),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.vector_base     (vector_base_q),
		.interrupt_level (irq_level_q),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.cmd             (cmd),
		.res_full        (res_full),
		.res_push        (res_push),
		.res             (res)
	);

	flasi_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_full (res_full),
		.res      (res),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

### rtl/core/flasi_checker.sv
// ----------------------------------------------------------------------------
// flasi_checker
// Port-level checks on the result channel of the serial interface.
// ----------------------------------------------------------------------------
module flasi_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            empty,
	input logic            pop,
	input flasi_pkg::out_t out_item
);
	import flasi_pkg::*;

	// A waiting beat holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result beat changed while stalled");

	// No character fields without a send
	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_item.tx_valid |-> out_item.tx_line == 2'd0 && out_item.tx_char == 7'd0)
		else $error("character fields set without a send");

	// No interrupt fields without a request
	a_irq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_item.irq_valid |->
			out_item.irq_vector == 9'd0 && out_item.irq_level == 3'd0)
		else $error("interrupt fields set without a request");

	// A send comes only from a write, which returns no data
	a_tx_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.tx_valid |-> out_item.read_data == 16'd0)
		else $error("read data on a transmit beat");

endmodule

bind four_line_async_serial_interface flasi_checker u_flasi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
